### hdl/rlde_pkg.sv
// ----------------------------------------------------------------------------
// rlde_pkg
// Shared types, constants and helpers for the run-length decimal count encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlde_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DIGIT_CAP       = 9999999;
  localparam int DIGIT_CAP_W     = 24;
  localparam int BCD_DIGITS      = 7;
  localparam int BURST_MAX       = 8;
  localparam int IDX_W           = 3;

  localparam logic [3:0] THRESH_MIN   = 4'd1;
  localparam logic [3:0] THRESH_MAX   = 4'd8;
  localparam logic [3:0] THRESH_RESET = 4'd4;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;

  localparam int         ADDR_W        = 3;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
    logic                      done;
  } burst_t;

  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (c) begin
        if (r[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = r[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] bcd_ndig(bcd_t v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (v[i] != 4'd0) n = IDX_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [3:0] bcd_digit(bcd_t v, logic [IDX_W-1:0] k);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (k == IDX_W'(i)) d = v[i];
    end
    return d;
  endfunction

  function automatic logic [3:0] eff_threshold(logic [3:0] t);
    logic [3:0] r;
    r = t;
    if (r < THRESH_MIN) r = THRESH_MIN;
    if (r > THRESH_MAX) r = THRESH_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rlde_encoder.sv
// ----------------------------------------------------------------------------
// rlde_encoder
// Run tracking and burst build: one request in, at most one burst of bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

module rlde_encoder #(
  parameter int COUNT_WIDTH = rlde_pkg::COUNT_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   accept,
  input  wire  [7:0]            in_byte,
  input  wire                   in_stream_end,
  input  wire  [3:0]            threshold,
  output logic                  burst_load,
  output rlde_pkg::burst_t      burst
);

  localparam int CNT_W = (COUNT_WIDTH < rlde_pkg::DIGIT_CAP_W) ?
                         COUNT_WIDTH : rlde_pkg::DIGIT_CAP_W;
  localparam longint RUN_MAX_I = (COUNT_WIDTH < rlde_pkg::DIGIT_CAP_W) ?
                                 ((64'd1 << COUNT_WIDTH) - 64'd1) :
                                 longint'(rlde_pkg::DIGIT_CAP);
  localparam logic [CNT_W-1:0] RUN_MAX = CNT_W'(RUN_MAX_I);

  logic [7:0]       prev_r;
  logic             open_r;
  logic [CNT_W-1:0] len_r;
  rlde_pkg::bcd_t   bcd_r;

  logic                          same;
  logic [CNT_W-1:0]              len_inc;
  rlde_pkg::bcd_t                bcd_inc;
  logic                          fl_en;
  logic [CNT_W-1:0]              fl_len;
  rlde_pkg::bcd_t                fl_bcd;
  logic                          fl_digits;
  logic [rlde_pkg::IDX_W-1:0]    ndig;
  logic [rlde_pkg::IDX_W-1:0]    fl_n;
  logic                          lit;
  logic [rlde_pkg::IDX_W:0]      n_res;

  always_comb begin
    same    = open_r && (in_byte == prev_r);
    len_inc = (len_r < RUN_MAX) ? len_r + CNT_W'(1) : len_r;
    bcd_inc = (len_r < RUN_MAX) ? rlde_pkg::bcd_inc(bcd_r) : bcd_r;

    if (same) begin
      fl_en  = in_stream_end;
      fl_len = len_inc;
      fl_bcd = bcd_inc;
    end else begin
      fl_en  = open_r;
      fl_len = len_r;
      fl_bcd = bcd_r;
    end

    fl_digits = fl_len > CNT_W'(threshold);
    ndig      = rlde_pkg::bcd_ndig(fl_bcd);
    if (!fl_en) begin
      fl_n = '0;
    end else if (fl_digits) begin
      fl_n = ndig;
    end else begin
      fl_n = fl_len[rlde_pkg::IDX_W-1:0] - rlde_pkg::IDX_W'(1);
    end

    lit   = !same;
    n_res = {1'b0, fl_n} + {{rlde_pkg::IDX_W{1'b0}}, lit};

    for (int i = 0; i < rlde_pkg::BURST_MAX; i++) begin
      if (rlde_pkg::IDX_W'(i) < fl_n && i < rlde_pkg::BURST_MAX - 1) begin
        if (fl_digits) begin
          burst.bytes[i] = rlde_pkg::ASCII_ZERO |
                           {4'd0, rlde_pkg::bcd_digit(fl_bcd,
                              ndig - rlde_pkg::IDX_W'(1) - rlde_pkg::IDX_W'(i))};
        end else begin
          burst.bytes[i] = prev_r;
        end
      end else begin
        burst.bytes[i] = in_byte;
      end
    end
    burst.last_idx = n_res[rlde_pkg::IDX_W-1:0] - rlde_pkg::IDX_W'(1);
    burst.done     = in_stream_end;
    burst_load     = accept && (n_res != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      open_r <= 1'b0;
      len_r  <= '0;
      bcd_r  <= '0;
    end else if (accept) begin
      if (same) begin
        len_r <= len_inc;
        bcd_r <= bcd_inc;
      end else begin
        prev_r <= in_byte;
        open_r <= 1'b1;
        len_r  <= CNT_W'(1);
        bcd_r  <= rlde_pkg::bcd_t'(1);
      end
      if (in_stream_end) begin
        open_r <= 1'b0;
        len_r  <= '0;
        bcd_r  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rlde_serializer.sv
// ----------------------------------------------------------------------------
// rlde_serializer
// Burst buffer and output register: send one byte of a burst per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module rlde_serializer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                burst_load,
  input  wire rlde_pkg::burst_t burst,
  output logic               burst_ready,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [7:0]         out_byte,
  output logic               out_burst_last,
  output logic               out_stream_done
);

  rlde_pkg::burst_t           buf_r;
  logic                       bv_r;
  logic [rlde_pkg::IDX_W-1:0] idx_r;

  logic       ov_r;
  logic [7:0] obyte_r;
  logic       olast_r;
  logic       odone_r;

  logic out_load;
  logic at_last;
  logic pop;

  always_comb begin
    out_load    = bv_r && (!ov_r || !out_stall);
    at_last     = idx_r == buf_r.last_idx;
    pop         = out_load && at_last;
    burst_ready = !bv_r || pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (out_load) begin
        idx_r <= at_last ? '0 : idx_r + rlde_pkg::IDX_W'(1);
      end
      if (burst_load) begin
        bv_r <= 1'b1;
      end else if (pop) begin
        bv_r <= 1'b0;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) buf_r <= burst;
    if (out_load) begin
      obyte_r <= buf_r.bytes[idx_r];
      olast_r <= at_last;
      odone_r <= at_last && buf_r.done;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = obyte_r;
  assign out_burst_last  = olast_r;
  assign out_stream_done = odone_r;

endmodule

`default_nettype wire

### hdl/run_length_decimal_count_encoder.sv
// ----------------------------------------------------------------------------
// run_length_decimal_count_encoder
// Byte-stream run-length encoder writing long runs as ASCII decimal counts.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_byte, in_stream_end
//   out      output     out_valid/out_stall out_byte, out_burst_last,
//                                           out_stream_done
//   cfg      input      APB psel/penable    count_threshold at byte 0
//
// One request a cycle is taken while the burst buffer is free; a request gives 0 to 8 output bytes.
// Output rate is one byte a cycle unless out_stall holds it, so a request with n results holds the
// burst buffer until all n are sent; every request waits for a free buffer.
// Run counts are kept in binary and BCD side by side.
// Reset is synchronous; all control state clears.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_decimal_count_encoder #(
  parameter int COUNT_WIDTH = rlde_pkg::COUNT_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [7:0]                 in_byte,
  input  wire                        in_stream_end,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_burst_last,
  output logic                       out_stream_done,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [rlde_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [3:0]       thr_r;
  logic             cfg_wr;
  logic             hit_thr;
  logic             accept;
  logic             burst_ready;
  logic             burst_load;
  rlde_pkg::burst_t burst;

  assign pready  = 1'b1;
  assign hit_thr = paddr[rlde_pkg::ADDR_W-1:2] == rlde_pkg::REG_THRESHOLD;
  assign cfg_wr  = psel && penable && pwrite && pready && hit_thr;
  assign prdata  = hit_thr ? {28'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rlde_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      thr_r <= pwdata[3:0];
    end
  end

  assign in_stall = !burst_ready;
  assign accept   = in_valid && burst_ready;

  rlde_encoder #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .threshold     (rlde_pkg::eff_threshold(thr_r)),
    .burst_load    (burst_load),
    .burst         (burst)
  );

  rlde_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .burst_load      (burst_load),
    .burst           (burst),
    .burst_ready     (burst_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_burst_last  (out_burst_last),
    .out_stream_done (out_stream_done)
  );

  a_end_gives_burst: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_stream_end |-> burst_load)
    else $error("stream end request gave no burst");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_burst_last)
    else $error("stream done on a non-final burst byte");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> thr_r == $past(pwdata[3:0]))
    else $error("threshold register not written");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    burst_load |-> burst_ready)
    else $error("burst loaded over a busy buffer");

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the run-length decimal count encoder. A predictor
// tracks the open run, its byte, its length and the threshold, and queues the
// codes that each accepted request must give. Results are compared in order,
// field by field. Directed runs cover the threshold edges, the clamped
// threshold settings, the end of a stream and a long run. Random streams
// follow under three idling mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int RUN_CAP =
    ((1 << rlde_pkg::COUNT_WIDTH_DEF) - 1 > rlde_pkg::DIGIT_CAP) ?
    rlde_pkg::DIGIT_CAP : (1 << rlde_pkg::COUNT_WIDTH_DEF) - 1;
  localparam logic [rlde_pkg::ADDR_W-1:0] THRESHOLD_ADDR =
    rlde_pkg::ADDR_W'(4 * rlde_pkg::REG_THRESHOLD);
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int LONG_RUN_LEN  = 24;
  localparam int RANDOM_BUDGET = 12;

  typedef struct packed {
    logic [7:0] code;
    logic       burst_last;
    logic       stream_done;
  } coded_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_byte = 8'h00;
  logic                        in_stream_end = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_byte;
  logic                        out_burst_last;
  logic                        out_stream_done;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rlde_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  coded_t      pending_codes[$];
  logic [7:0]  burst_bytes[$];
  coded_t      want;
  logic [3:0]  threshold_cfg = rlde_pkg::THRESH_RESET;
  logic        run_active = 1'b0;
  logic [7:0]  run_byte = 8'h00;
  int unsigned run_count = 0;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;

  run_length_decimal_count_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_burst_last  (out_burst_last),
    .out_stream_done (out_stream_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_threshold(logic [3:0] t);
    if (t < rlde_pkg::THRESH_MIN) return 32'(rlde_pkg::THRESH_MIN);
    if (t > rlde_pkg::THRESH_MAX) return 32'(rlde_pkg::THRESH_MAX);
    return 32'(t);
  endfunction

  function automatic void append_flush();
    logic [7:0]  digits[$];
    int unsigned len;
    len = run_count;
    if (len > clamp_threshold(threshold_cfg)) begin
      while (len > 0) begin
        digits.push_front(rlde_pkg::ASCII_ZERO + 8'(len % 10));
        len = len / 10;
      end
      foreach (digits[k]) burst_bytes.push_back(digits[k]);
    end else begin
      for (int unsigned k = 1; k < len; k++) burst_bytes.push_back(run_byte);
    end
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic last);
    int n;
    burst_bytes.delete();
    if (run_active && b == run_byte) begin
      if (run_count < RUN_CAP) run_count++;
    end else begin
      if (run_active) append_flush();
      burst_bytes.push_back(b);
      run_byte   = b;
      run_active = 1'b1;
      run_count  = 1;
    end
    if (last) begin
      append_flush();
      run_active = 1'b0;
      run_count  = 0;
    end
    n = burst_bytes.size();
    for (int i = 0; i < n; i++) begin
      pending_codes.push_back('{code: burst_bytes[i], burst_last: (i == n - 1),
                                stream_done: last && (i == n - 1)});
    end
  endfunction

  // predict on every accepted request, then check every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold_cfg = rlde_pkg::THRESH_RESET;
      run_active    = 1'b0;
      run_byte      = 8'h00;
      run_count     = 0;
      pending_codes.delete();
    end else begin
      if (psel && penable && pready && paddr == THRESHOLD_ADDR) begin
        if (pwrite) begin
          threshold_cfg = pwdata[3:0];
        end else if (prdata !== 32'(threshold_cfg)) begin
          $error("prdata expected %h actual %h", 32'(threshold_cfg), prdata);
          mismatch_count++;
        end
      end
      if (in_valid && !in_stall) encode_byte(in_byte, in_stream_end);
      if (out_valid && !out_stall) begin
        if (pending_codes.size() == 0) begin
          $error("out_byte expected none actual %h", out_byte);
          mismatch_count++;
        end else begin
          want = pending_codes.pop_front();
          if (out_byte !== want.code) begin
            $error("out_byte expected %h actual %h", want.code, out_byte);
            mismatch_count++;
          end
          if (out_burst_last !== want.burst_last) begin
            $error("out_burst_last expected %b actual %b", want.burst_last, out_burst_last);
            mismatch_count++;
          end
          if (out_stream_done !== want.stream_done) begin
            $error("out_stream_done expected %b actual %b", want.stream_done,
                   out_stream_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= hold_request || (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic offer_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_stream_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write, then read back in the following transfer
  task automatic write_threshold(logic [3:0] value);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= {28'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed_runs();
    offer_byte(8'h00, 1'b1);
    repeat (4) offer_byte(8'hFF, 1'b0);
    repeat (5) offer_byte(8'h41, 1'b0);
    offer_byte(8'h42, 1'b1);
    offer_byte(8'h7E, 1'b0);
    offer_byte(8'h7E, 1'b1);
    offer_byte(8'h7E, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(4'd0);
    offer_byte(8'h55, 1'b0);
    offer_byte(8'h55, 1'b1);
    write_threshold(4'd15);
    repeat (8) offer_byte(8'hAA, 1'b0);
    offer_byte(8'hAB, 1'b1);
    write_threshold(4'd8);
    repeat (8) offer_byte(8'h6D, 1'b0);
    offer_byte(8'h6D, 1'b1);
    write_threshold(4'd1);
    offer_byte(8'h20, 1'b0);
    offer_byte(8'h21, 1'b1);
  endtask

  task automatic test_random_streams(int unsigned budget);
    int unsigned sent;
    int unsigned runs;
    int unsigned len;
    logic [7:0]  b;
    sent = 0;
    write_threshold(4'($urandom_range(15)));
    while (sent < budget) begin
      if ($urandom_range(99) < 15) begin
        offer_byte(8'($urandom), 1'($urandom));
        sent++;
      end else begin
        runs = $urandom_range(1, 5);
        for (int unsigned r = 0; r < runs; r++) begin
          b   = ($urandom_range(3) == 0) ? 8'(8'h41 + $urandom_range(1)) : 8'($urandom);
          len = ($urandom_range(9) == 0) ? $urandom_range(11, 25) : $urandom_range(1, 10);
          for (int unsigned k = 0; k < len; k++) begin
            offer_byte(b, (r == runs - 1) && (k == len - 1));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_output_holdoff();
    write_threshold(4'd3);
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    for (int i = 0; i < 40; i++) offer_byte(8'(i * 37 + 1), i == 39);
  endtask

  task automatic test_long_run();
    write_threshold(4'd8);
    for (int i = 0; i < LONG_RUN_LEN; i++) offer_byte(8'h5A, i == LONG_RUN_LEN - 1);
  endtask

  initial begin
    set_idling(33, 59);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_threshold_extremes();
    test_random_streams(RANDOM_BUDGET);
    set_idling(59, 33);
    test_random_streams(RANDOM_BUDGET);
    set_idling(0, 0);
    test_random_streams(RANDOM_BUDGET);
    test_output_holdoff();
    test_long_run();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("run_length_decimal_count_encoder verification clean");
    end else begin
      $display("run_length_decimal_count_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("run_length_decimal_count_encoder verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hdl/rlde_pkg.sv
hdl/rlde_encoder.sv
hdl/rlde_serializer.sv
hdl/run_length_decimal_count_encoder.sv
verif/testbench.sv
